// File: sv/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// Shared constants and a helper function for the ultrasonic ranging
// scheduler: item kinds, report kinds, register indexes and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package urs_pkg;

   // Field widths fixed by the interface.
   localparam int DATA_W      = 16;
   localparam int KIND_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int SENSOR_W    = 2;
   localparam int CSR_INDEX_W = 8;

   // Default number of sensors in the round robin.
   localparam int NUM_SENSORS_DEFAULT = 3;

   // Item kinds carried on the request channel.
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EDGE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HOST = 2'd2;

   // Report kinds carried on the response channel.
   localparam logic [1:0] REPORT_NONE  = 2'd0;
   localparam logic [1:0] REPORT_VALUE = 2'd1;
   localparam logic [1:0] REPORT_TERM  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_DIVISOR  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_PERIOD = 8'd1;

   // Register reset values.
   localparam logic [DATA_W-1:0] ECHO_DIVISOR_RESET  = 16'd58;
   localparam logic [DATA_W-1:0] REPORT_PERIOD_RESET = 16'd200;

   // Host command codes after the ASCII offset is removed.
   localparam logic [BYTE_W-1:0] ASCII_BASE = 8'd48;
   localparam logic [BYTE_W-1:0] CMD_NONE   = 8'd0;
   localparam logic [BYTE_W-1:0] CMD_SLEEP  = 8'd4;
   localparam logic [BYTE_W-1:0] CMD_WAKE   = 8'd5;

   // Largest byte over the ASCII base gives the number of subtract steps.
   localparam int MOD_STEPS = 255 / 48;

   // Reduce a host byte modulo the ASCII base by conditional subtraction.
   function automatic logic [BYTE_W-1:0] strip_ascii(input logic [BYTE_W-1:0] raw);
      logic [BYTE_W-1:0] value;
      value = raw;
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (value >= ASCII_BASE) begin
            value = value - ASCII_BASE;
         end
      end
      return value;
   endfunction

endpackage

`default_nettype wire

// File: sv/urs_divider.sv
// ----------------------------------------------------------------------------
// urs_divider
// Iterative restoring divider: one quotient bit per cycle through a single
// shared subtract and compare. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module urs_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [urs_pkg::DATA_W-1:0]  dividend,
   input  wire logic [urs_pkg::DATA_W-1:0]  divisor,
   output logic                             done,
   output logic      [urs_pkg::DATA_W-1:0]  quotient
);

   localparam int COUNT_W = $clog2(urs_pkg::DATA_W + 1);

   logic                        busy_ff,  busy_in;
   logic                        done_ff,  done_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic [urs_pkg::DATA_W-1:0]  rem_ff,   rem_in;
   logic [urs_pkg::DATA_W-1:0]  quo_ff,   quo_in;
   logic [urs_pkg::DATA_W-1:0]  div_ff,   div_in;
   logic [urs_pkg::DATA_W:0]    trial;
   logic [urs_pkg::DATA_W:0]    diff;

   // Shift the next dividend bit into the partial remainder and try the subtract.
   assign trial = {rem_ff, quo_ff[urs_pkg::DATA_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = COUNT_W'(urs_pkg::DATA_W);
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[urs_pkg::DATA_W]) begin
            rem_in = diff[urs_pkg::DATA_W-1:0];
            quo_in = {quo_ff[urs_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[urs_pkg::DATA_W-1:0];
            quo_in = {quo_ff[urs_pkg::DATA_W-2:0], 1'b0};
         end
         count_in = count_ff - COUNT_W'(1);
         if (count_ff == COUNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: sv/ultrasonic_ranging_scheduler_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranging_scheduler_core
// Round-robin trigger and report scheduler for several ultrasonic sensors,
// with echo width to distance conversion and a host sleep and wake control.
// ----------------------------------------------------------------------------
// Ticks, host bytes and rising edges give their registered response in the
// cycle after acceptance; a falling edge answers once the divider is done.
// Throughput: one transaction per cycle when the response side keeps up. The
// block takes a new request only while it is idle, not while it divides.
// Synchronous reset restores the state and configuration registers.
`default_nettype none

module ultrasonic_ranging_scheduler_core #(
   parameter int NUM_SENSORS = urs_pkg::NUM_SENSORS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [urs_pkg::KIND_W-1:0]       req_cmd,
   input  wire logic [urs_pkg::DATA_W-1:0]       req_capture_time,
   input  wire logic [urs_pkg::BYTE_W-1:0]       req_host_byte,
   // Response channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_trigger_fire,
   output logic      [urs_pkg::SENSOR_W-1:0]     rsp_trigger_sensor,
   output logic      [1:0]                       rsp_report_kind,
   output logic      [urs_pkg::DATA_W-1:0]       rsp_report_value,
   output logic                                  rsp_power_cut,
   output logic                                  rsp_asleep,
   // Configuration write channel.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [urs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [urs_pkg::DATA_W-1:0]       csr_wdata
);

   localparam int DW = urs_pkg::DATA_W;
   localparam int BW = urs_pkg::BYTE_W;
   localparam int SW = urs_pkg::SENSOR_W;

   typedef enum logic [0:0] {
      S_IDLE,
      S_DIVIDE
   } state_type;

   state_type          state_ff, state_in;

   logic [DW-1:0]      echo_divisor_ff,  echo_divisor_in;
   logic [DW-1:0]      report_period_ff, report_period_in;
   logic [BW-1:0]      pending_ff,       pending_in;
   logic               sleeping_ff,      sleeping_in;
   logic [DW-1:0]      tick_ff,          tick_in;
   logic [SW-1:0]      next_sensor_ff,   next_sensor_in;
   logic [SW-1:0]      measured_ff,      measured_in;
   logic               expect_fall_ff,   expect_fall_in;
   logic [DW-1:0]      rise_ff,          rise_in;
   logic [DW-1:0]      dist_ff [NUM_SENSORS];
   logic [DW-1:0]      dist_in [NUM_SENSORS];

   logic               rsp_valid_ff,     rsp_valid_in;
   logic               rsp_fire_ff,      rsp_fire_in;
   logic [SW-1:0]      rsp_sensor_ff,    rsp_sensor_in;
   logic [1:0]         rsp_kind_ff,      rsp_kind_in;
   logic [DW-1:0]      rsp_value_ff,     rsp_value_in;

   logic               req_accept;
   logic               div_start;
   logic               div_done;
   logic [DW-1:0]      div_quotient;
   logic [DW-1:0]      echo_width;
   logic [BW-1:0]      host_code;
   logic [DW-1:0]      query_value;
   logic [SW:0]        sensor_step;

   // Shared divider that turns an echo width into a distance.
   urs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (echo_width),
      .divisor  (echo_divisor_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // A request is taken only when idle and the response register is empty or emptying.
   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign echo_width  = req_capture_time - rise_ff;
   assign host_code   = urs_pkg::strip_ascii(req_host_byte);
   assign sensor_step = {1'b0, next_sensor_ff} + (SW+1)'(1);

   // Stored distance of the queried sensor; queries count sensors from one.
   always_comb begin
      query_value = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (pending_ff == BW'(i + 1)) begin
            query_value = dist_ff[i];
         end
      end
   end

   // Sequencer and item processing.
   always_comb begin
      state_in         = state_ff;
      echo_divisor_in  = echo_divisor_ff;
      report_period_in = report_period_ff;
      pending_in       = pending_ff;
      sleeping_in      = sleeping_ff;
      tick_in          = tick_ff;
      next_sensor_in   = next_sensor_ff;
      measured_in      = measured_ff;
      expect_fall_in   = expect_fall_ff;
      rise_in          = rise_ff;
      dist_in          = dist_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_fire_in      = rsp_fire_ff;
      rsp_sensor_in    = rsp_sensor_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_value_in     = rsp_value_ff;
      div_start        = 1'b0;

      // Configuration writes; indexes beyond the list are dropped.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            urs_pkg::CSR_ECHO_DIVISOR:  echo_divisor_in  = csr_wdata;
            urs_pkg::CSR_REPORT_PERIOD: report_period_in = csr_wdata;
            default: ;
         endcase
      end

      // The response register empties when its transaction completes.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in  = 1'b1;
               rsp_fire_in   = 1'b0;
               rsp_sensor_in = '0;
               rsp_kind_in   = urs_pkg::REPORT_NONE;
               rsp_value_in  = '0;
               case (req_cmd)
                  urs_pkg::KIND_HOST: begin
                     // A new byte is only taken when no command is pending.
                     if (pending_ff == urs_pkg::CMD_NONE) begin
                        pending_in = host_code;
                        if (host_code == urs_pkg::CMD_SLEEP) begin
                           sleeping_in = 1'b1;
                           pending_in  = urs_pkg::CMD_NONE;
                        end else if (host_code == urs_pkg::CMD_WAKE) begin
                           sleeping_in = 1'b0;
                           pending_in  = urs_pkg::CMD_NONE;
                        end else if (sleeping_ff && host_code < urs_pkg::CMD_SLEEP) begin
                           pending_in = urs_pkg::CMD_NONE;
                        end
                     end
                  end
                  urs_pkg::KIND_TICK: begin
                     if (!sleeping_ff) begin
                        if (tick_ff >= report_period_ff) begin
                           // End of period: trigger the next sensor in turn.
                           tick_in       = '0;
                           rsp_fire_in   = 1'b1;
                           rsp_sensor_in = next_sensor_ff;
                           measured_in   = next_sensor_ff;
                           if (sensor_step >= (SW+1)'(NUM_SENSORS)) begin
                              next_sensor_in = '0;
                           end else begin
                              next_sensor_in = sensor_step[SW-1:0];
                           end
                           // Answer a pending command, then clear it.
                           if (pending_ff != urs_pkg::CMD_NONE) begin
                              if (pending_ff <= BW'(NUM_SENSORS)) begin
                                 rsp_kind_in  = urs_pkg::REPORT_VALUE;
                                 rsp_value_in = query_value;
                              end else begin
                                 rsp_kind_in  = urs_pkg::REPORT_TERM;
                              end
                              pending_in = urs_pkg::CMD_NONE;
                           end
                        end else begin
                           tick_in = tick_ff + DW'(1);
                        end
                     end
                  end
                  urs_pkg::KIND_EDGE: begin
                     if (!sleeping_ff) begin
                        expect_fall_in = !expect_fall_ff;
                        if (!expect_fall_ff) begin
                           rise_in = req_capture_time;
                        end else begin
                           // Falling edge: hold the response until the divide ends.
                           rsp_valid_in = 1'b0;
                           div_start    = 1'b1;
                           state_in     = S_DIVIDE;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               for (int i = 0; i < NUM_SENSORS; i++) begin
                  if (measured_ff == SW'(i)) begin
                     dist_in[i] = div_quotient;
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         echo_divisor_ff  <= urs_pkg::ECHO_DIVISOR_RESET;
         report_period_ff <= urs_pkg::REPORT_PERIOD_RESET;
         pending_ff       <= urs_pkg::CMD_NONE;
         sleeping_ff      <= 1'b0;
         tick_ff          <= '0;
         next_sensor_ff   <= '0;
         measured_ff      <= '0;
         expect_fall_ff   <= 1'b0;
         rise_ff          <= '0;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            dist_ff[i] <= '0;
         end
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         echo_divisor_ff  <= echo_divisor_in;
         report_period_ff <= report_period_in;
         pending_ff       <= pending_in;
         sleeping_ff      <= sleeping_in;
         tick_ff          <= tick_in;
         next_sensor_ff   <= next_sensor_in;
         measured_ff      <= measured_in;
         expect_fall_ff   <= expect_fall_in;
         rise_ff          <= rise_in;
         dist_ff          <= dist_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_fire_ff   <= rsp_fire_in;
      rsp_sensor_ff <= rsp_sensor_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Power state always shows the state after the last transaction.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trigger_fire   = rsp_fire_ff;
   assign rsp_trigger_sensor = rsp_sensor_ff;
   assign rsp_report_kind    = rsp_kind_ff;
   assign rsp_report_value   = rsp_value_ff;
   assign rsp_power_cut      = sleeping_ff;
   assign rsp_asleep         = sleeping_ff;

endmodule

`default_nettype wire

// File: tb/ultrasonic_ranging_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranging_scheduler_core_tb
// Self-checking bench for the ultrasonic ranging scheduler. A transaction
// predictor tracks ticks, echo edges, host commands and the sleep state. It
// computes one expected response per accepted transaction, and a checker
// compares each response field by field. Stimulus runs directed cases,
// register extremes, random phases under several settings, back-pressure,
// and the sleep lockout case.
// ----------------------------------------------------------------------------

module ultrasonic_ranging_scheduler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import urs_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE       = 24;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SENSORS      = NUM_SENSORS_DEFAULT;
   localparam int PHASE_ITEMS  = 230;

   // Item kind that the block has no use for.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Expected content of one response transaction.
   typedef struct packed {
      logic                fire;
      logic [SENSOR_W-1:0] sensor;
      logic [1:0]          report;
      logic [DATA_W-1:0]   value;
      logic                power_cut;
      logic                asleep;
   } ranging_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_cmd          = KIND_TICK;
   logic [DATA_W-1:0]      req_capture_time = '0;
   logic [BYTE_W-1:0]      req_host_byte    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic                   rsp_trigger_fire;
   logic [SENSOR_W-1:0]    rsp_trigger_sensor;
   logic [1:0]             rsp_report_kind;
   logic [DATA_W-1:0]      rsp_report_value;
   logic                   rsp_power_cut;
   logic                   rsp_asleep;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [DATA_W-1:0]      csr_wdata        = '0;

   // Predicted block state and configuration.
   logic [DATA_W-1:0]   pred_divisor  = ECHO_DIVISOR_RESET;
   logic [DATA_W-1:0]   pred_period   = REPORT_PERIOD_RESET;
   logic [BYTE_W-1:0]   pred_pending  = CMD_NONE;
   logic                pred_sleeping = 1'b0;
   logic [DATA_W-1:0]   pred_ticks    = '0;
   logic [SENSOR_W-1:0] pred_next     = '0;
   logic [SENSOR_W-1:0] pred_measured = '0;
   logic                pred_falling  = 1'b0;
   logic [DATA_W-1:0]   pred_rise     = '0;
   logic [DATA_W-1:0]   pred_dist [SENSORS] = '{default: '0};

   ranging_result_t expected_reports [$];
   ranging_result_t oldest_report;

   // Run statistics and control shared between processes.
   int  mismatches     = 0;
   int  items_sent     = 0;
   int  cycle_count    = 0;
   int  fire_count     = 0;
   int  value_reports  = 0;
   int  term_reports   = 0;
   int  conversions    = 0;
   int  dropped_asleep = 0;
   int  settings_count = 0;
   int  ready_hold     = 0;
   bit  steady_send    = 1'b0;
   bit  steady_recv    = 1'b0;

   ultrasonic_ranging_scheduler_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_capture_time   (req_capture_time),
      .req_host_byte      (req_host_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_trigger_fire   (rsp_trigger_fire),
      .rsp_trigger_sensor (rsp_trigger_sensor),
      .rsp_report_kind    (rsp_report_kind),
      .rsp_report_value   (rsp_report_value),
      .rsp_power_cut      (rsp_power_cut),
      .rsp_asleep         (rsp_asleep),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Free-running clock.
   always #CLOCK_HALF clock = ~clock;

   // Advance the predicted state by one transaction and return its response.
   function automatic ranging_result_t predict_ranging(input logic [KIND_W-1:0] kind,
                                                       input logic [DATA_W-1:0] cap,
                                                       input logic [BYTE_W-1:0] hbyte);
      ranging_result_t   r;
      logic [BYTE_W-1:0] code;
      logic [DATA_W-1:0] span;
      r = '0;
      if (kind == KIND_HOST) begin
         // A byte that arrives while a command is pending is dropped.
         if (pred_pending == CMD_NONE) begin
            code = hbyte % ASCII_BASE;
            if (code == CMD_SLEEP) begin
               pred_sleeping = 1'b1;
               code = CMD_NONE;
            end else if (code == CMD_WAKE) begin
               pred_sleeping = 1'b0;
               code = CMD_NONE;
            end else if (pred_sleeping && code < CMD_SLEEP) begin
               code = CMD_NONE;
            end
            pred_pending = code;
         end
      end else if (kind == KIND_TICK) begin
         if (pred_sleeping) begin
            dropped_asleep++;
         end else if (pred_ticks >= pred_period) begin
            // Period end: trigger the next sensor and answer any pending query.
            pred_ticks = '0;
            r.fire = 1'b1;
            r.sensor = pred_next;
            pred_measured = pred_next;
            pred_next = (pred_next == SENSORS - 1) ? '0 : pred_next + 1'b1;
            fire_count++;
            if (pred_pending != CMD_NONE) begin
               if (pred_pending <= SENSORS) begin
                  r.report = REPORT_VALUE;
                  r.value = pred_dist[pred_pending - 1];
                  value_reports++;
               end else begin
                  r.report = REPORT_TERM;
                  term_reports++;
               end
               pred_pending = CMD_NONE;
            end
         end else begin
            pred_ticks = pred_ticks + 1'b1;
         end
      end else if (kind == KIND_EDGE) begin
         if (pred_sleeping) begin
            dropped_asleep++;
         end else begin
            // Edges alternate; the falling one converts the width to distance.
            if (!pred_falling) begin
               pred_rise = cap;
            end else begin
               span = cap - pred_rise;
               pred_dist[pred_measured] = (pred_divisor == '0) ? '1 : span / pred_divisor;
               conversions++;
            end
            pred_falling = ~pred_falling;
         end
      end
      r.power_cut = pred_sleeping;
      r.asleep = pred_sleeping;
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Offer one request transaction, sometimes with a random idle gap ahead of it.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] cap,
                            input logic [BYTE_W-1:0] hbyte);
      int gap;
      if (!steady_send && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 24);
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= kind;
      req_capture_time <= cap;
      req_host_byte    <= hbyte;
      do @(posedge clock); while (!req_ready);
      expected_reports.push_back(predict_ranging(kind, cap, hbyte));
      items_sent++;
   endtask

   // Stop offering and wait until every outstanding response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_ECHO_DIVISOR) begin
         pred_divisor = data;
      end else if (index == CSR_REPORT_PERIOD) begin
         pred_period = data;
      end
   endtask

   // New register setting on an idle block; an unmapped index is written too.
   task automatic configure_block(input bit set_divisor, input logic [DATA_W-1:0] divisor,
                                  input logic [DATA_W-1:0] period);
      wait_idle();
      write_reg(CSR_INDEX_W'($urandom_range(CSR_REPORT_PERIOD + 1, 255)), DATA_W'($urandom));
      if (set_divisor) begin
         write_reg(CSR_ECHO_DIVISOR, divisor);
      end
      write_reg(CSR_REPORT_PERIOD, period);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // One random sequence: mostly well-formed activity, some noise.
   task automatic random_episode();
      int                sel;
      int                count;
      logic [DATA_W-1:0] rise;
      logic [DATA_W-1:0] span;
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] hbyte;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         count = $urandom_range(1, (pred_period > 10) ? 32 : pred_period + 2);
         repeat (count) send_item(KIND_TICK, DATA_W'($urandom), BYTE_W'($urandom));
      end else if (sel < 60) begin
         rise = DATA_W'($urandom);
         span = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom)
                                            : DATA_W'($urandom_range(0, 4000));
         send_item(KIND_EDGE, rise, BYTE_W'($urandom));
         send_item(KIND_EDGE, rise + span, BYTE_W'($urandom));
      end else if (sel < 80) begin
         // Sensor query, as a digit or a raw value with up to five times 48 added.
         hbyte = BYTE_W'($urandom_range(1, SENSORS) + ASCII_BASE * $urandom_range(0, 5));
         send_item(KIND_HOST, DATA_W'($urandom), hbyte);
      end else if (sel < 88) begin
         hbyte = BYTE_W'(CMD_SLEEP + ASCII_BASE * $urandom_range(0, 5));
         send_item(KIND_HOST, DATA_W'($urandom), hbyte);
         count = $urandom_range(1, 4);
         repeat (count) begin
            kind = KIND_W'($urandom_range(0, 2));
            hbyte = BYTE_W'($urandom_range(0, SENSORS) + ASCII_BASE * $urandom_range(0, 5));
            send_item(kind, DATA_W'($urandom), hbyte);
         end
         hbyte = BYTE_W'(CMD_WAKE + ASCII_BASE * $urandom_range(0, 5));
         send_item(KIND_HOST, DATA_W'($urandom), hbyte);
      end else begin
         kind = KIND_W'($urandom_range(0, 3));
         hbyte = BYTE_W'($urandom);
         // An unknown command while asleep would lock the block until reset.
         if (pred_sleeping && (hbyte % ASCII_BASE) > CMD_WAKE) begin
            hbyte = BYTE_W'(hbyte - (hbyte % ASCII_BASE) + $urandom_range(0, CMD_WAKE));
         end
         send_item(kind, DATA_W'($urandom), hbyte);
      end
   endtask

   // Reset divisor kept; every special case of the command path once.
   task automatic test_directed_cases();
      configure_block(1'b0, '0, '0);
      send_item(KIND_UNUSED, 16'hFFFF, 8'hFF);
      send_item(KIND_EDGE, 16'hFF00, 8'h00);
      send_item(KIND_EDGE, 16'h1000, 8'h00);
      send_item(KIND_HOST, 16'h0000, ASCII_BASE + 8'd1);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_HOST, 16'h0000, 8'hFF);
      send_item(KIND_HOST, 16'h0000, ASCII_BASE + 8'd2);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_HOST, 16'h0000, ASCII_BASE + CMD_SLEEP);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_EDGE, 16'h1234, 8'h00);
      send_item(KIND_HOST, 16'h0000, ASCII_BASE + 8'd1);
      send_item(KIND_HOST, 16'h0000, ASCII_BASE * 8'd2 + CMD_WAKE);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_HOST, 16'h0000, 8'h00);
   endtask

   // Largest period and divisor, then a lowered period and a zero divisor.
   task automatic test_register_extremes();
      configure_block(1'b1, 16'hFFFF, 16'hFFFF);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_EDGE, 16'h0000, 8'h00);
      send_item(KIND_EDGE, 16'hFFFF, 8'h00);
      configure_block(1'b1, 16'h0000, 16'd1);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_EDGE, 16'h8000, 8'h00);
      send_item(KIND_EDGE, 16'h8000, 8'h00);
      send_item(KIND_HOST, 16'h0000, ASCII_BASE + 8'd1);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_TICK, 16'h0000, 8'h00);
   endtask

   // Random traffic under several register settings.
   task automatic test_random_phases();
      logic [DATA_W-1:0] divisor;
      logic [DATA_W-1:0] period;
      int                target;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin divisor = 16'd1;     period = 16'd0;  end
            1: begin divisor = 16'hFFFF;  period = 16'd4;  end
            2: begin divisor = 16'd0;     period = 16'd2;  end
            3: begin divisor = ECHO_DIVISOR_RESET; period = 16'd12; end
            4: begin
               divisor = DATA_W'($urandom_range(1, 65535));
               period  = DATA_W'($urandom_range(0, 8));
            end
            5: begin
               divisor = DATA_W'($urandom_range(1, 200));
               period  = DATA_W'($urandom_range(0, 8));
            end
            6: begin divisor = 16'd40;    period = 16'd30; end
            default: begin divisor = ECHO_DIVISOR_RESET; period = 16'd6; end
         endcase
         configure_block(1'b1, divisor, period);
         // One phase runs with neither side idling.
         steady_send = (p == 6);
         steady_recv = (p == 6);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) random_episode();
         steady_send = 1'b0;
         steady_recv = 1'b0;
      end
   endtask

   // Receiver holds off while requests keep coming, then the sender drains.
   task automatic test_input_backpressure();
      int target;
      wait_idle();
      steady_send = 1'b1;
      ready_hold = 300;
      target = items_sent + 40;
      while (items_sent < target) random_episode();
      steady_send = 1'b0;
      wait_idle();
   endtask

   // An unknown command taken while asleep locks out everything, wake included.
   task automatic test_sleep_lockout();
      configure_block(1'b0, '0, '0);
      if (pred_sleeping) begin
         send_item(KIND_HOST, 16'h0000, ASCII_BASE + CMD_WAKE);
      end
      while (pred_pending != CMD_NONE) send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_HOST, 16'h0000, CMD_SLEEP);
      send_item(KIND_HOST, 16'h0000, ASCII_BASE + 8'd6);
      send_item(KIND_HOST, 16'h0000, ASCII_BASE + CMD_WAKE);
      send_item(KIND_TICK, 16'h0000, 8'h00);
      send_item(KIND_EDGE, 16'h0042, 8'h00);
   endtask

   // Response acceptance with random stalls and a counted long hold-off.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold--;
      end else begin
         rsp_ready <= steady_recv || ($urandom_range(0, 99) >= 29);
      end
   end

   // Compare every accepted response against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual fire %0d report %0d",
                     $time, rsp_trigger_fire, rsp_report_kind);
            mismatches++;
         end else begin
            oldest_report = expected_reports.pop_front();
            check_field("trigger_fire", 32'(oldest_report.fire), 32'(rsp_trigger_fire));
            check_field("trigger_sensor", 32'(oldest_report.sensor),
                        32'(rsp_trigger_sensor));
            check_field("report_kind", 32'(oldest_report.report), 32'(rsp_report_kind));
            check_field("report_value", 32'(oldest_report.value), 32'(rsp_report_value));
            check_field("power_cut", 32'(oldest_report.power_cut), 32'(rsp_power_cut));
            check_field("asleep", 32'(oldest_report.asleep), 32'(rsp_asleep));
         end
      end
   end

   // Watchdog on the total cycle count.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_count, expected_reports.size());
      $display("FAIL");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_random_phases();
      test_input_backpressure();
      test_sleep_lockout();
      wait_idle();
      $display("Covered %0d transactions in %0d cycles over %0d settings: %0d triggers,",
               items_sent, cycle_count, settings_count, fire_count);
      $display("%0d distance reports, %0d terminator reports, %0d conversions, %0d dropped asleep.",
               value_reports, term_reports, conversions, dropped_asleep);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/urs_pkg.sv
sv/urs_divider.sv
sv/ultrasonic_ranging_scheduler_core.sv
tb/ultrasonic_ranging_scheduler_core_tb.sv
